### design/spbe_pkg.sv
// ----------------------------------------------------------------------------
// spbe_pkg
// Shared types and constants for the spectrum peak and band energy core.
// ----------------------------------------------------------------------------
package spbe_pkg;

  localparam int IN_W       = 16;          // width of one complex component
  localparam int MAG_W      = 16;          // width of a bin magnitude
  localparam int SQ_W       = 32;          // width of re^2 + im^2
  localparam int ENERGY_W   = 31;          // width of a squared magnitude
  localparam int BAND_W     = 36;          // width of a band sum
  localparam int PEAK_W     = 6;           // width of the reported peak bin
  localparam int ROOT_STEPS = SQ_W / 2;    // one result bit per step
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = MAG_W + 3;   // remainder after one step, with headroom
  localparam int BAND_COUNT = 3;

  localparam logic [MAG_W-1:0]  MAG_MAX  = MAG_W'(46340);
  localparam logic [BAND_W-1:0] BAND_MAX = '1;
  localparam logic [SQ_W-1:0]   SQ_MAX   = SQ_W'(64'h8000_0000);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQ_RE  = 6'b000010,
    S_SQ_IM  = 6'b000100,
    S_ROOT   = 6'b001000,
    S_SQ_MAG = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;    // capture the absolute values of a new bin
    logic sq_re;      // radicand = |re|^2
    logic sq_im;      // radicand += |im|^2, prepare the square root
    logic root_step;  // one step of the square root
    logic sq_mag;     // energy = magnitude^2
    logic update;     // fold the bin into the frame statistics
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_last;   // the current square root step is the final one
    logic frame_last;  // the bin in work is the last of its frame
    logic out_full;    // the result register cannot take a new result
  } status_t;

endpackage

### design/spbe_ctrl.sv
// ----------------------------------------------------------------------------
// spbe_ctrl
// Controller state machine: sequences squaring, square root and update.
// ----------------------------------------------------------------------------
module spbe_ctrl
  import spbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        cmd.sq_re  = 1'b1;
        state_next = S_SQ_IM;
      end
      S_SQ_IM: begin
        cmd.sq_im  = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = S_SQ_MAG;
        end
      end
      S_SQ_MAG: begin
        cmd.sq_mag = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // A frame result waits here while the previous one is still unread.
        if (!(status.frame_last && status.out_full)) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/spbe_dp.sv
// ----------------------------------------------------------------------------
// spbe_dp
// Datapath: shared multiplier, bit-serial square root, frame statistics and
// the result register.
// ----------------------------------------------------------------------------
module spbe_dp
  import spbe_pkg::*;
#(
  parameter int BINS = 64
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic signed [IN_W-1:0]   real_part,
  input  logic signed [IN_W-1:0]   imag_part,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PEAK_W-1:0]        peak_bin,
  output logic [MAG_W-1:0]         peak_magnitude,
  output logic [ENERGY_W-1:0]      dc_energy,
  output logic [BAND_W-1:0]        low_band_energy,
  output logic [BAND_W-1:0]        mid_band_energy,
  output logic [BAND_W-1:0]        high_band_energy
);

  localparam int BAND_LEN = (BINS - 1) / 3;
  localparam int CW       = $clog2(BINS);
  localparam int PW       = $clog2(BAND_LEN + 1);

  // Operands and multiplier.
  logic [IN_W-1:0]  re_abs;
  logic [IN_W-1:0]  im_abs;
  logic [MAG_W-1:0] mul_a;
  logic [SQ_W-1:0]  prod;

  // Square root.
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [MAG_W-1:0]  root;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // Frame statistics.
  logic [ENERGY_W-1:0] energy;
  logic [CW-1:0]       cnt;
  logic [1:0]          band;
  logic [PW-1:0]       pos;
  logic [MAG_W-1:0]    best_mag;
  logic [CW-1:0]       best_bin;
  logic [ENERGY_W-1:0] dc_sum;
  logic [BAND_W-1:0]   band_sums [BAND_COUNT];

  logic                is_dc;
  logic                take_peak;
  logic [BAND_W:0]     sum_ext;
  logic [BAND_W-1:0]   sat_sum;
  logic [MAG_W-1:0]    best_mag_next;
  logic [CW-1:0]       best_bin_next;
  logic [ENERGY_W-1:0] dc_next;
  logic [BAND_W-1:0]   band_next [BAND_COUNT];

  always_comb begin
    mul_a = root;
    if (cmd.sq_re) begin
      mul_a = re_abs;
    end else if (cmd.sq_im) begin
      mul_a = im_abs;
    end
  end

  assign prod = mul_a * mul_a;

  // One root digit per step: bring down two radicand bits, try 4*root+1.
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      re_abs <= real_part[IN_W-1] ? IN_W'(-real_part) : IN_W'(real_part);
      im_abs <= imag_part[IN_W-1] ? IN_W'(-imag_part) : IN_W'(imag_part);
    end
    if (cmd.sq_re) begin
      rad <= prod;
    end else if (cmd.sq_im) begin
      rad  <= rad + prod;
      rem  <= '0;
      root <= '0;
      step <= STEP_W'(ROOT_STEPS - 1);
    end else if (cmd.root_step) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      step <= step - 1'b1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.sq_mag) begin
      energy <= prod[ENERGY_W-1:0];
    end
  end

  assign status.root_last  = (step == '0);
  assign status.frame_last = (cnt == CW'(BINS - 1));
  assign status.out_full   = out_valid && !out_ready;

  // Next values of the statistics with the current bin folded in.
  assign is_dc     = (cnt == '0);
  assign take_peak = !is_dc && (root >= best_mag);
  assign sum_ext   = {1'b0, band_sums[band]} + (BAND_W + 1)'(energy);
  assign sat_sum   = sum_ext[BAND_W] ? BAND_MAX : sum_ext[BAND_W-1:0];

  assign best_mag_next = take_peak ? root : best_mag;
  assign best_bin_next = take_peak ? cnt : best_bin;
  assign dc_next       = is_dc ? energy : dc_sum;

  always_comb begin
    for (int i = 0; i < BAND_COUNT; i++) begin
      band_next[i] = (!is_dc && band == 2'(i)) ? sat_sum : band_sums[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      band     <= '0;
      pos      <= '0;
      best_mag <= '0;
      best_bin <= '0;
      dc_sum   <= '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        band_sums[i] <= '0;
      end
    end else if (cmd.update) begin
      if (status.frame_last) begin
        cnt      <= '0;
        band     <= '0;
        pos      <= '0;
        best_mag <= '0;
        best_bin <= '0;
        dc_sum   <= '0;
        for (int i = 0; i < BAND_COUNT; i++) begin
          band_sums[i] <= '0;
        end
      end else begin
        cnt      <= cnt + 1'b1;
        best_mag <= best_mag_next;
        best_bin <= best_bin_next;
        dc_sum   <= dc_next;
        for (int i = 0; i < BAND_COUNT; i++) begin
          band_sums[i] <= band_next[i];
        end
        if (!is_dc) begin
          if (pos == PW'(BAND_LEN - 1)) begin
            if (band != 2'd2) begin
              band <= band + 1'b1;
              pos  <= '0;
            end
          end else begin
            pos <= pos + 1'b1;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update && status.frame_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && status.frame_last) begin
      peak_bin         <= PEAK_W'(best_bin_next);
      peak_magnitude   <= best_mag_next;
      dc_energy        <= dc_next;
      low_band_energy  <= band_next[0];
      mid_band_energy  <= band_next[1];
      high_band_energy <= band_next[2];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.sq_im |=> rad <= SQ_MAX)
    else $error("Sum of squares exceeds its bound.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.sq_mag |-> root <= MAG_MAX)
    else $error("Square root result exceeds the largest magnitude.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.update && status.frame_last) |-> !(out_valid && !out_ready))
    else $error("A frame result would overwrite an unread result.");

  assert property (@(posedge clk) disable iff (rst)
    band != 2'd3)
    else $error("Band index out of range.");

endmodule

### design/spectrum_peak_and_band_energy_core.sv
// ----------------------------------------------------------------------------
// spectrum_peak_and_band_energy_core
// Peak bin search and band energy sums over one frame of FFT bins.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready, real_part, imag_part) carries
// one complex FFT bin per transaction, bin 0 of a frame first and BINS bins
// per frame. The output channel (out_valid/out_ready and the six result
// ports) carries one transaction per frame, after its last bin: the peak
// bin over bins 1 to BINS-1 (the later bin wins a tie), its magnitude, the
// DC energy and three band energies of (BINS-1)/3 bins (high takes any rest).
// Each bin passes through these steps in order before the next input
// transaction is accepted: accept, re^2 and im^2 on the shared multiplier,
// the bit-serial square root (one result bit per cycle), squaring of the
// magnitude and the fold into the statistics. The frame result is loaded
// into the output register in the update step of its last bin.
// The result sits in an output register, so the next frame's bins are
// accepted while it waits; only the last bin of the following frame is held
// in its update step while an earlier result is still unread.
// Reset clears the bin position, the statistics and the output valid flag.
// ----------------------------------------------------------------------------
module spectrum_peak_and_band_energy_core
  import spbe_pkg::*;
#(
  parameter int BINS = 64
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] real_part,
  input  logic signed [IN_W-1:0] imag_part,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PEAK_W-1:0]      peak_bin,
  output logic [MAG_W-1:0]       peak_magnitude,
  output logic [ENERGY_W-1:0]    dc_energy,
  output logic [BAND_W-1:0]      low_band_energy,
  output logic [BAND_W-1:0]      mid_band_energy,
  output logic [BAND_W-1:0]      high_band_energy
);

  // Commands and status between the sequencer and the arithmetic.
  cmd_t    cmd;
  status_t status;

  // The controller decides when a bin is taken and steps the datapath
  // through squaring, the square root and the statistics update.
  spbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the shared multiplier, the square root, the frame
  // statistics and the result register.
  spbe_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .real_part        (real_part),
    .imag_part        (imag_part),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .peak_bin         (peak_bin),
    .peak_magnitude   (peak_magnitude),
    .dc_energy        (dc_energy),
    .low_band_energy  (low_band_energy),
    .mid_band_energy  (mid_band_energy),
    .high_band_energy (high_band_energy)
  );

endmodule
